>>> rtl/wbrm_pkg.sv
`default_nettype none

package wbrm_pkg;

    localparam int WAVE_W      = 16;
    localparam int BAND_W      = 8;
    localparam int VBW_W       = 12;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROBE_W     = 3;

    localparam logic [BAND_W-1:0]  NO_BAND    = 8'hFF;
    localparam logic [WAVE_W-1:0]  WIDE_LIMIT = 16'd3000;
    localparam logic [10:0]        WIDE_HALF  = 11'd500;
    localparam logic [VBW_W-1:0]   VBW_RESET  = 12'd15;
    localparam logic [PROBE_W-1:0] GREEN_LAST = 3'd4;

    // Register index of visible_band_width, taken from paddr[2].
    localparam logic REG_VBW_IDX = 1'b0;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2,
        OP_GREEN = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QCHK,
        S_GCHK,
        S_LSETUP,
        S_LCHK,
        S_LWRITE,
        S_RESP
    } state_t;

    function automatic logic [WAVE_W-1:0] green_probe(input logic [PROBE_W-1:0] k);
        logic [WAVE_W-1:0] p;
        unique case (k)
            3'd0:    p = 16'd545;
            3'd1:    p = 16'd550;
            3'd2:    p = 16'd555;
            3'd3:    p = 16'd560;
            default: p = 16'd565;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

>>> rtl/wbrm_ifs.sv
`default_nettype none

interface wbrm_req_if import wbrm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [WAVE_W-1:0] wavelength;

    modport source (output valid, output opcode, output wavelength, input ready);
    modport sink   (input valid, input opcode, input wavelength, output ready);
endinterface

interface wbrm_rsp_if import wbrm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [BAND_W-1:0] band_number;
    logic                     status;

    modport source (output valid, output band_number, output status, input ready);
    modport sink   (input valid, input band_number, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/wavelength_band_range_map_top.sv
`default_nettype none

// Wavelength band map: a table of TABLE_DEPTH bytes in one synchronous RAM maps each whole
// wavelength from WAVE_BASE upward to a band number, 0xFF meaning no band. After reset and
// after every clear word the block sweeps the whole table and takes no word meanwhile;
// configuration writes are accepted at any time. A green query makes one RAM read per probe
// point until a probe hits or the last one is read, and a load writes its table entries one
// at a time, since the RAM has one write port; a load refused at the band limit writes nothing.
// Each result then waits in an output register until the sink takes it, while the next
// word is already being worked on.
module wavelength_band_range_map_top
    import wbrm_pkg::*;
#(
    parameter int TABLE_DEPTH = 16384,
    parameter int WAVE_BASE   = 300,
    parameter int MAX_BANDS   = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    wbrm_req_if.sink                   req,
    wbrm_rsp_if.source                 rsp
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CW     = 18;
    localparam logic signed [CW-1:0] BASE_S  = CW'(WAVE_BASE);
    localparam logic signed [CW-1:0] TOP_S   = CW'(WAVE_BASE + TABLE_DEPTH - 1);
    localparam logic signed [CW-1:0] DEPTH_S = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0]        BASE_U  = CW'(WAVE_BASE);
    localparam logic [CW-1:0]        END_U   = CW'(WAVE_BASE + TABLE_DEPTH);

    logic [BAND_W-1:0] band_mem [TABLE_DEPTH];

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                    clr_resp_reg, clr_resp_next;
    logic [BAND_W-1:0]       bands_reg, bands_next;
    logic [WAVE_W-1:0]       prev_reg, prev_next;
    logic [WAVE_W-1:0]       centre_reg, centre_next;
    logic signed [CW-1:0]    lo_reg, lo_next;
    logic signed [CW-1:0]    hi_reg, hi_next;
    logic [PROBE_W-1:0]      probe_reg, probe_next;
    logic                    hit_ok_reg, hit_ok_next;
    logic [BAND_W-1:0]       res_band_reg, res_band_next;
    logic                    res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [BAND_W-1:0]       out_band_reg, out_band_next;
    logic                    out_status_reg, out_status_next;
    logic [VBW_W-1:0]        vbw_reg;
    logic [BAND_W-1:0]       rdata_reg;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [BAND_W-1:0]       mem_wdata;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_raddr;

    logic [CW-1:0]           q_wave;
    logic                    q_in;
    logic [CW-1:0]           q_off;
    logic [PROBE_W-1:0]      probe_sel;
    logic [CW-1:0]           g_wave;
    logic                    g_in;
    logic [CW-1:0]           g_off;
    logic [10:0]             half;
    logic signed [CW-1:0]    c_s;
    logic signed [CW-1:0]    h_s;
    logic signed [CW-1:0]    lo_raw;
    logic signed [CW-1:0]    lo_off;
    logic signed [CW-1:0]    hi_raw;
    logic signed [CW-1:0]    hi_off;
    logic signed [CW-1:0]    diff;
    logic signed [CW-1:0]    diff_adj;
    logic signed [CW-1:0]    mid;
    logic signed [CW-1:0]    mid_off;
    logic [BAND_W-1:0]       g_band;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VBW_IDX) ? CFG_DATA_W'(vbw_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbw_reg <= VBW_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_VBW_IDX)
        begin
            vbw_reg <= pwdata[VBW_W-1:0];
        end
    end

    // Table RAM with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            band_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= band_mem[mem_raddr];
        end
    end

    // Address arithmetic for queries, green probes and load windows.
    always_comb
    begin
        q_wave    = CW'(req.wavelength);
        q_in      = (q_wave >= BASE_U) && (q_wave < END_U);
        q_off     = q_wave - BASE_U;
        probe_sel = (state_reg == S_IDLE) ? '0 : probe_reg + 1'b1;
        g_wave    = CW'(green_probe(probe_sel));
        g_in      = (g_wave >= BASE_U) && (g_wave < END_U);
        g_off     = g_wave - BASE_U;

        half   = (centre_reg > WIDE_LIMIT) ? WIDE_HALF : vbw_reg[VBW_W-1:1];
        c_s    = $signed(CW'(centre_reg));
        h_s    = $signed(CW'(half));
        lo_raw = c_s - h_s;
        lo_off = ((lo_raw < BASE_S) ? BASE_S : lo_raw) - BASE_S;
        hi_raw = c_s + h_s;
        hi_off = ((hi_raw > TOP_S) ? TOP_S : hi_raw) - BASE_S;

        diff     = c_s - $signed(CW'(prev_reg));
        diff_adj = diff + $signed(CW'(diff[CW-1]));
        mid      = c_s - (diff_adj >>> 1);
        mid_off  = ((mid < BASE_S) ? BASE_S : mid) - BASE_S;

        g_band = hit_ok_reg ? rdata_reg : NO_BAND;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_resp_next   = clr_resp_reg;
        bands_next      = bands_reg;
        prev_next       = prev_reg;
        centre_next     = centre_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        probe_next      = probe_reg;
        hit_ok_next     = hit_ok_reg;
        res_band_next   = res_band_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_band_next   = out_band_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = NO_BAND;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        req.ready       = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    clr_cnt_next    = '0;
                    clr_resp_next   = 1'b0;
                    res_band_next   = NO_BAND;
                    res_status_next = 1'b0;
                    state_next      = clr_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    unique case (op_t'(req.opcode))
                        OP_CLEAR:
                        begin
                            bands_next    = '0;
                            prev_next     = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        OP_LOAD:
                        begin
                            if (bands_reg >= BAND_W'(MAX_BANDS))
                            begin
                                res_band_next   = NO_BAND;
                                res_status_next = 1'b1;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                centre_next     = req.wavelength;
                                res_band_next   = bands_reg;
                                res_status_next = 1'b0;
                                state_next      = S_LSETUP;
                            end
                        end
                        OP_QUERY:
                        begin
                            mem_re      = 1'b1;
                            mem_raddr   = q_off[ADDR_W-1:0];
                            hit_ok_next = q_in;
                            state_next  = S_QCHK;
                        end
                        OP_GREEN:
                        begin
                            mem_re      = 1'b1;
                            mem_raddr   = g_off[ADDR_W-1:0];
                            hit_ok_next = g_in;
                            probe_next  = '0;
                            state_next  = S_GCHK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_QCHK:
            begin
                res_band_next   = hit_ok_reg ? rdata_reg : NO_BAND;
                res_status_next = 1'b0;
                state_next      = S_RESP;
            end
            S_GCHK:
            begin
                if (g_band != NO_BAND || probe_reg == GREEN_LAST)
                begin
                    res_band_next   = g_band;
                    res_status_next = 1'b0;
                    state_next      = S_RESP;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = g_off[ADDR_W-1:0];
                    hit_ok_next = g_in;
                    probe_next  = probe_sel;
                end
            end
            S_LSETUP:
            begin
                lo_next = lo_off;
                hi_next = hi_off;
                if (lo_off < DEPTH_S)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = lo_off[ADDR_W-1:0];
                    state_next = S_LCHK;
                end
                else
                begin
                    bands_next = bands_reg + 1'b1;
                    prev_next  = centre_reg;
                    state_next = S_RESP;
                end
            end
            S_LCHK:
            begin
                // An owned low end moves to the midpoint with the previous centre.
                if (rdata_reg != NO_BAND)
                begin
                    lo_next = mid_off;
                end
                state_next = S_LWRITE;
            end
            S_LWRITE:
            begin
                if (lo_reg <= hi_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = lo_reg[ADDR_W-1:0];
                    mem_wdata = bands_reg;
                    lo_next   = lo_reg + 1'b1;
                end
                else
                begin
                    bands_next = bands_reg + 1'b1;
                    prev_next  = centre_reg;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_band_next   = res_band_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            clr_resp_reg  <= 1'b0;
            bands_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_resp_reg  <= clr_resp_next;
            bands_reg     <= bands_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        centre_reg     <= centre_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        probe_reg      <= probe_next;
        hit_ok_reg     <= hit_ok_next;
        res_band_reg   <= res_band_next;
        res_status_reg <= res_status_next;
        out_band_reg   <= out_band_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.band_number = $signed(out_band_reg);
    assign rsp.status      = out_status_reg;

endmodule

`default_nettype wire
